// ----- design/owsm_pkg.sv -----
`timescale 1ns / 1ps

package owsm_pkg;

    // Command codes on the input side
    localparam logic [2:0] CMD_TICK      = 3'd0;
    localparam logic [2:0] CMD_RESET     = 3'd1;
    localparam logic [2:0] CMD_WRITE     = 3'd2;
    localparam logic [2:0] CMD_READ      = 3'd3;
    localparam logic [2:0] CMD_CONVERT   = 3'd4;
    localparam logic [2:0] CMD_READ_TEMP = 3'd5;

    // Bus command bytes
    localparam logic [7:0] ROM_SKIP      = 8'hCC;
    localparam logic [7:0] FN_CONVERT    = 8'h44;
    localparam logic [7:0] FN_READ_PAD   = 8'hBE;

    // Configuration register file
    localparam int         CFG_W         = 12;
    localparam int         CFG_COUNT     = 7;
    localparam logic [2:0] CFG_RST_LOW   = 3'd0;
    localparam logic [2:0] CFG_PRES_WAIT = 3'd1;
    localparam logic [2:0] CFG_RST_REC   = 3'd2;
    localparam logic [2:0] CFG_WR_LOW    = 3'd3;
    localparam logic [2:0] CFG_HOLD      = 3'd4;
    localparam logic [2:0] CFG_RD_LOW    = 3'd5;
    localparam logic [2:0] CFG_RD_SAMPLE = 3'd6;

    localparam logic [CFG_W-1:0] CFG_RST_LOW_INIT   = 12'd500;
    localparam logic [CFG_W-1:0] CFG_PRES_WAIT_INIT = 12'd70;
    localparam logic [CFG_W-1:0] CFG_RST_REC_INIT   = 12'd500;
    localparam logic [CFG_W-1:0] CFG_WR_LOW_INIT    = 12'd10;
    localparam logic [CFG_W-1:0] CFG_HOLD_INIT      = 12'd50;
    localparam logic [CFG_W-1:0] CFG_RD_LOW_INIT    = 12'd5;
    localparam logic [CFG_W-1:0] CFG_RD_SAMPLE_INIT = 12'd5;

    // Steps in a command sequence
    localparam logic [2:0] SEQ_LAST      = 3'd4;
    localparam logic [2:0] STEP_TEMP_LO  = 3'd3;
    localparam logic [2:0] STEP_TEMP_HI  = 3'd4;
    localparam logic [2:0] BIT_LAST      = 3'd7;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_RESET  = 3'd1,
        OP_WCONST = 3'd2,
        OP_WTX    = 3'd3,
        OP_READ   = 3'd4
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] data;
    } seq_op_t;

    // Classified input word
    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       bus_level;
    } item_t;

    // Result word
    typedef struct packed {
        logic               drive_low;
        logic               busy_res;
        logic               done_res;
        logic               presence_level;
        logic [7:0]         rx_byte;
        logic signed [15:0] temperature_raw;
        logic               command_ignored;
    } result_t;

    // Handshake between the front queue and the engine
    typedef struct packed {
        logic avail;
        logic take;
    } link_t;

    // Bus operation for a given command and step
    function automatic seq_op_t seq_op(input logic [2:0] cmd, input logic [2:0] step);
        seq_op_t op;
        op.kind = OP_NONE;
        op.data = 8'h00;
        case (cmd)
            CMD_RESET:
            begin
                if (step == 3'd0) op.kind = OP_RESET;
            end
            CMD_WRITE:
            begin
                if (step == 3'd0) op.kind = OP_WTX;
            end
            CMD_READ:
            begin
                if (step == 3'd0) op.kind = OP_READ;
            end
            CMD_CONVERT:
            begin
                case (step)
                    3'd0: op.kind = OP_RESET;
                    3'd1:
                    begin
                        op.kind = OP_WCONST;
                        op.data = ROM_SKIP;
                    end
                    3'd2:
                    begin
                        op.kind = OP_WCONST;
                        op.data = FN_CONVERT;
                    end
                    default: op.kind = OP_NONE;
                endcase
            end
            CMD_READ_TEMP:
            begin
                case (step)
                    3'd0: op.kind = OP_RESET;
                    3'd1:
                    begin
                        op.kind = OP_WCONST;
                        op.data = ROM_SKIP;
                    end
                    3'd2:
                    begin
                        op.kind = OP_WCONST;
                        op.data = FN_READ_PAD;
                    end
                    3'd3: op.kind = OP_READ;
                    3'd4: op.kind = OP_READ;
                    default: op.kind = OP_NONE;
                endcase
            end
            default: op.kind = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

// ----- design/one_wire_sensor_master.sv -----
`timescale 1ns / 1ps

// Channel   Handshake      Words
// input     push / full    command, tx_byte, bus_level (one bus tick each)
// result    empty / pop    drive_low, busy_res, done_res, presence_level,
//                          rx_byte, temperature_raw, command_ignored
// config    cfg_write      cfg_index, cfg_data (no wait, no read-back)
//
// One tick word in, one result word out; one word per cycle sustained while the result queue is not full.
// A taken word passes through a two-entry input queue, then the sequencer
// step into a two-entry result queue, from whose head the result ports are driven.
// The sequencer stalls only when the result queue is full; the input queue
// keeps taking words meanwhile until it too fills.
// Reset (rst_n low) empties both queues, idles the bus, loads default timings.

module one_wire_sensor_master #(
    parameter int TIMER_BITS = 12
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [2:0]                 command,
    input  logic [7:0]                 tx_byte,
    input  logic                       bus_level,
    output logic                       empty,
    input  logic                       pop,
    output logic                       drive_low,
    output logic                       busy_res,
    output logic                       done_res,
    output logic                       presence_level,
    output logic [7:0]                 rx_byte,
    output logic signed [15:0]         temperature_raw,
    output logic                       command_ignored,
    input  logic                       cfg_write,
    input  logic [2:0]                 cfg_index,
    input  logic [owsm_pkg::CFG_W-1:0] cfg_data
);
    import owsm_pkg::*;

    item_t   item;
    logic    avail;
    link_t   link;
    logic    res_full;
    logic    res_push;
    result_t res_word;
    result_t head;

    owsm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .command   (command),
        .tx_byte   (tx_byte),
        .bus_level (bus_level),
        .item      (item),
        .link_in   (link),
        .avail     (avail)
    );

    owsm_engine #(
        .TIMER_BITS (TIMER_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .avail     (avail),
        .link_out  (link),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_word  (res_word)
    );

    owsm_resq u_resq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (res_push),
        .wr_word  (res_word),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

    // Drive the result ports from the queue head
    assign drive_low       = head.drive_low;
    assign busy_res        = head.busy_res;
    assign done_res        = head.done_res;
    assign presence_level  = head.presence_level;
    assign rx_byte         = head.rx_byte;
    assign temperature_raw = head.temperature_raw;
    assign command_ignored = head.command_ignored;

    // The sequencer never steps into a full result queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("sequencer stepped while result queue full");

    // A stepped word is waiting on the result side in the next cycle
    a_step_visible: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> !empty)
        else $error("stepped word missing from result queue");

    // A finishing tick always leaves the master idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && done_res) |-> !busy_res)
        else $error("done flagged while still busy");

endmodule

// ----- design/owsm_front.sv -----
`timescale 1ns / 1ps

module owsm_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  logic [2:0]      command,
    input  logic [7:0]      tx_byte,
    input  logic            bus_level,
    output owsm_pkg::item_t item,
    input  owsm_pkg::link_t link_in,
    output logic            avail
);
    import owsm_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;
    item_t      classified;

    // Classify the incoming word
    always_comb
    begin
        classified.cmd_valid = (command >= CMD_RESET) && (command <= CMD_READ_TEMP);
        classified.command   = command;
        classified.tx_byte   = tx_byte;
        classified.bus_level = bus_level;
    end

    assign full    = (count_reg == 2'd2);
    assign avail   = (count_reg != 2'd0);
    assign do_push = push && !full;
    assign do_pop  = link_in.take && link_in.avail;
    assign item    = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

// ----- design/owsm_engine.sv -----
`timescale 1ns / 1ps

module owsm_engine #(
    parameter int TIMER_BITS = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [2:0]                     cfg_index,
    input  logic [owsm_pkg::CFG_W-1:0]     cfg_data,
    input  owsm_pkg::item_t                item,
    input  logic                           avail,
    output owsm_pkg::link_t                link_out,
    input  logic                           res_full,
    output logic                           res_push,
    output owsm_pkg::result_t              res_word
);
    import owsm_pkg::*;

    localparam int CW = ((TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W) + 1;
    localparam logic [CW-1:0] LIM = CW'(1) << TIMER_BITS;

    typedef enum logic [7:0] {
        PH_IDLE     = 8'b0000_0001,
        PH_RST_LOW  = 8'b0000_0010,
        PH_RST_WAIT = 8'b0000_0100,
        PH_RST_REC  = 8'b0000_1000,
        PH_WR_LOW   = 8'b0001_0000,
        PH_RD_LOW   = 8'b0010_0000,
        PH_RD_WAIT  = 8'b0100_0000,
        PH_HOLD     = 8'b1000_0000
    } phase_t;

    logic [CFG_W-1:0]      cfg_reg [CFG_COUNT];
    phase_t                phase_reg, phase_next;
    logic [2:0]            step_reg, step_next;
    logic [2:0]            cmd_reg, cmd_next;
    logic [TIMER_BITS-1:0] cnt_reg, cnt_next;
    logic [2:0]            bit_reg, bit_next;
    logic [7:0]            shift_reg, shift_next;
    logic [7:0]            rx_reg, rx_next;
    logic [7:0]            tlo_reg, tlo_next;
    logic [15:0]           temp_reg, temp_next;
    logic                  pres_reg, pres_next;

    logic                  take;
    logic [CFG_W-1:0]      len_sel;
    logic [CW-1:0]         len;
    logic [CW-1:0]         cnt_plus;
    seq_op_t               cur_op;
    seq_op_t               nxt_op;
    seq_op_t               new_op;
    seq_op_t               out_op;
    logic                  start;
    logic [7:0]            start_tx;
    logic                  finish;
    logic                  done;
    logic                  ignored;
    logic                  drive;

    assign take          = avail && !res_full;
    assign link_out.take = take;
    assign link_out.avail = avail;
    assign res_push      = take;

    // Length of the running phase, zero read as one, saturated to the timer
    always_comb
    begin
        case (phase_reg)
            PH_RST_LOW:  len_sel = cfg_reg[CFG_RST_LOW];
            PH_RST_WAIT: len_sel = cfg_reg[CFG_PRES_WAIT];
            PH_RST_REC:  len_sel = cfg_reg[CFG_RST_REC];
            PH_WR_LOW:   len_sel = cfg_reg[CFG_WR_LOW];
            PH_HOLD:     len_sel = cfg_reg[CFG_HOLD];
            PH_RD_LOW:   len_sel = cfg_reg[CFG_RD_LOW];
            default:     len_sel = cfg_reg[CFG_RD_SAMPLE];
        endcase
        len = CW'(len_sel);
        if (len == '0) len = CW'(1);
        if (len > LIM) len = LIM;
        cnt_plus = CW'(cnt_reg) + CW'(1);
    end

    assign cur_op = seq_op(cmd_reg, step_reg);
    assign nxt_op = seq_op(cmd_reg, step_reg + 3'd1);

    // Step the bus sequencer by one tick
    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        cmd_next   = cmd_reg;
        cnt_next   = cnt_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        rx_next    = rx_reg;
        tlo_next   = tlo_reg;
        temp_next  = temp_reg;
        pres_next  = pres_reg;
        start      = 1'b0;
        start_tx   = 8'h00;
        finish     = 1'b0;
        done       = 1'b0;
        ignored    = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            if (item.cmd_valid)
            begin
                cmd_next  = item.command;
                step_next = 3'd0;
                start     = 1'b1;
                start_tx  = item.tx_byte;
            end
        end
        else
        begin
            ignored = item.cmd_valid;
            if (cnt_plus < len)
            begin
                cnt_next = cnt_plus[TIMER_BITS-1:0];
            end
            else
            begin
                cnt_next = '0;
                case (phase_reg)
                    PH_RST_LOW:  phase_next = PH_RST_WAIT;
                    PH_RST_WAIT:
                    begin
                        pres_next  = item.bus_level;
                        phase_next = PH_RST_REC;
                    end
                    PH_RST_REC:  finish = 1'b1;
                    PH_WR_LOW:   phase_next = PH_HOLD;
                    PH_RD_LOW:   phase_next = PH_RD_WAIT;
                    PH_RD_WAIT:
                    begin
                        if (item.bus_level) shift_next[bit_reg] = 1'b1;
                        phase_next = PH_HOLD;
                    end
                    PH_HOLD:
                    begin
                        if (bit_reg == BIT_LAST)
                        begin
                            if (cur_op.kind == OP_READ)
                            begin
                                rx_next = shift_reg;
                                if (cmd_reg == CMD_READ_TEMP && step_reg == STEP_TEMP_LO)
                                    tlo_next = shift_reg;
                                else if (cmd_reg == CMD_READ_TEMP && step_reg == STEP_TEMP_HI)
                                    temp_next = {shift_reg, tlo_reg};
                            end
                            finish = 1'b1;
                        end
                        else
                        begin
                            bit_next   = bit_reg + 3'd1;
                            phase_next = (cur_op.kind == OP_READ) ? PH_RD_LOW : PH_WR_LOW;
                        end
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
        end

        // Close the operation and move to the next step or finish
        if (finish)
        begin
            if (step_reg == SEQ_LAST || nxt_op.kind == OP_NONE)
            begin
                phase_next = PH_IDLE;
                step_next  = 3'd0;
                cnt_next   = '0;
                done       = 1'b1;
            end
            else
            begin
                step_next = step_reg + 3'd1;
                start     = 1'b1;
            end
        end

        // Open the operation at the current step
        new_op = seq_op(cmd_next, step_next);
        if (start)
        begin
            cnt_next = '0;
            bit_next = 3'd0;
            case (new_op.kind)
                OP_RESET:  phase_next = PH_RST_LOW;
                OP_WCONST:
                begin
                    shift_next = new_op.data;
                    phase_next = PH_WR_LOW;
                end
                OP_WTX:
                begin
                    shift_next = start_tx;
                    phase_next = PH_WR_LOW;
                end
                OP_READ:
                begin
                    shift_next = 8'h00;
                    phase_next = PH_RD_LOW;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    step_next  = 3'd0;
                    done       = 1'b1;
                end
            endcase
        end
    end

    // Line drive after this tick
    assign out_op = seq_op(cmd_next, step_next);
    always_comb
    begin
        if (phase_next == PH_RST_LOW || phase_next == PH_WR_LOW || phase_next == PH_RD_LOW)
            drive = 1'b1;
        else if (phase_next == PH_HOLD && out_op.kind != OP_READ)
            drive = !shift_next[bit_next];
        else
            drive = 1'b0;
    end

    // Assemble the result word
    always_comb
    begin
        res_word.drive_low       = drive;
        res_word.busy_res        = (phase_next != PH_IDLE);
        res_word.done_res        = done;
        res_word.presence_level  = pres_next;
        res_word.rx_byte         = rx_next;
        res_word.temperature_raw = temp_next;
        res_word.command_ignored = ignored;
    end

    // Hold the sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            step_reg  <= 3'd0;
            cmd_reg   <= CMD_TICK;
            cnt_reg   <= '0;
            bit_reg   <= 3'd0;
            shift_reg <= 8'h00;
            rx_reg    <= 8'h00;
            tlo_reg   <= 8'h00;
            temp_reg  <= 16'h0000;
            pres_reg  <= 1'b1;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            cmd_reg   <= cmd_next;
            cnt_reg   <= cnt_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            rx_reg    <= rx_next;
            tlo_reg   <= tlo_next;
            temp_reg  <= temp_next;
            pres_reg  <= pres_next;
        end
    end

    // Timing registers, indexes past the last one dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[CFG_RST_LOW]   <= CFG_RST_LOW_INIT;
            cfg_reg[CFG_PRES_WAIT] <= CFG_PRES_WAIT_INIT;
            cfg_reg[CFG_RST_REC]   <= CFG_RST_REC_INIT;
            cfg_reg[CFG_WR_LOW]    <= CFG_WR_LOW_INIT;
            cfg_reg[CFG_HOLD]      <= CFG_HOLD_INIT;
            cfg_reg[CFG_RD_LOW]    <= CFG_RD_LOW_INIT;
            cfg_reg[CFG_RD_SAMPLE] <= CFG_RD_SAMPLE_INIT;
        end
        else if (cfg_write && (cfg_index <= CFG_RD_SAMPLE))
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

endmodule

// ----- design/owsm_resq.sv -----
`timescale 1ns / 1ps

module owsm_resq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  owsm_pkg::result_t wr_word,
    output logic              res_full,
    output logic              empty,
    input  logic              pop,
    output owsm_pkg::result_t head
);
    import owsm_pkg::*;

    result_t    slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    assign res_full = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_pop   = pop && !empty;
    assign head     = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(wr) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the result word
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_word;
        end
    end

endmodule

// ----- test/tb_one_wire_sensor_master.sv -----
`timescale 1ns / 1ps

module tb_one_wire_sensor_master;
    import owsm_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;

    // Codes the block treats as a plain tick, and the index it has no register for
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;
    localparam logic [2:0] CFG_SPARE   = 3'd7;

    // How the sampled line level is chosen while a command runs
    localparam int BUS_LOW    = 0;
    localparam int BUS_HIGH   = 1;
    localparam int BUS_RANDOM = 2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_REC,
        PH_WR_LOW,
        PH_RD_LOW,
        PH_RD_WAIT,
        PH_HOLD
    } slot_phase_t;

    // Bus master predictor plus the store of expected result words
    class sensor_bus_model;
        logic [CFG_W-1:0] timing [CFG_COUNT];
        slot_phase_t      phase;
        logic [2:0]       step;
        logic [2:0]       cmd_now;
        int unsigned      ticks;
        logic [2:0]       bit_no;
        logic [7:0]       shifter;
        logic [7:0]       rx_last;
        logic [7:0]       temp_lo;
        logic [15:0]      temp_word;
        logic             presence;
        bit               done;
        result_t          pending_results [$];
        int               mismatch_count;
        int               checked_count;

        function new();
            timing[CFG_RST_LOW]   = CFG_RST_LOW_INIT;
            timing[CFG_PRES_WAIT] = CFG_PRES_WAIT_INIT;
            timing[CFG_RST_REC]   = CFG_RST_REC_INIT;
            timing[CFG_WR_LOW]    = CFG_WR_LOW_INIT;
            timing[CFG_HOLD]      = CFG_HOLD_INIT;
            timing[CFG_RD_LOW]    = CFG_RD_LOW_INIT;
            timing[CFG_RD_SAMPLE] = CFG_RD_SAMPLE_INIT;
            phase = PH_IDLE;
            step = 3'd0;
            cmd_now = CMD_TICK;
            ticks = 0;
            bit_no = 3'd0;
            shifter = 8'h00;
            rx_last = 8'h00;
            temp_lo = 8'h00;
            temp_word = 16'h0000;
            presence = 1'b1;
            done = 1'b0;
            mismatch_count = 0;
            checked_count = 0;
        endfunction

        function bit idle();
            return phase == PH_IDLE;
        endfunction

        // Bus operation of the running command at the current step
        function void op_at_step(output op_kind_t kind, output logic [7:0] data);
            kind = OP_NONE;
            data = 8'h00;
            case (cmd_now)
                CMD_RESET:  if (step == 3'd0) kind = OP_RESET;
                CMD_WRITE:  if (step == 3'd0) kind = OP_WTX;
                CMD_READ:   if (step == 3'd0) kind = OP_READ;
                CMD_CONVERT, CMD_READ_TEMP:
                begin
                    if (step == 3'd0)
                        kind = OP_RESET;
                    else if (step == 3'd1)
                    begin
                        kind = OP_WCONST;
                        data = ROM_SKIP;
                    end
                    else if (step == 3'd2)
                    begin
                        kind = OP_WCONST;
                        data = (cmd_now == CMD_CONVERT) ? FN_CONVERT : FN_READ_PAD;
                    end
                    else if (cmd_now == CMD_READ_TEMP && step <= STEP_TEMP_HI)
                        kind = OP_READ;
                end
                default: ;
            endcase
        endfunction

        // Length of a phase in ticks; zero counts as one
        function int unsigned span(slot_phase_t ph);
            logic [CFG_W-1:0] d;
            case (ph)
                PH_RST_LOW:  d = timing[CFG_RST_LOW];
                PH_RST_WAIT: d = timing[CFG_PRES_WAIT];
                PH_RST_REC:  d = timing[CFG_RST_REC];
                PH_WR_LOW:   d = timing[CFG_WR_LOW];
                PH_HOLD:     d = timing[CFG_HOLD];
                PH_RD_LOW:   d = timing[CFG_RD_LOW];
                default:     d = timing[CFG_RD_SAMPLE];
            endcase
            return (d == 0) ? 1 : d;
        endfunction

        function void open_bus_op(logic [7:0] tx);
            op_kind_t   kind;
            logic [7:0] data;
            op_at_step(kind, data);
            ticks = 0;
            bit_no = 3'd0;
            case (kind)
                OP_RESET: phase = PH_RST_LOW;
                OP_WCONST, OP_WTX:
                begin
                    shifter = (kind == OP_WTX) ? tx : data;
                    phase = PH_WR_LOW;
                end
                OP_READ:
                begin
                    shifter = 8'h00;
                    phase = PH_RD_LOW;
                end
                default:
                begin
                    phase = PH_IDLE;
                    step = 3'd0;
                    done = 1'b1;
                end
            endcase
        endfunction

        // Move to the next step, or end the command
        function void close_bus_op();
            op_kind_t   kind;
            logic [7:0] data;
            step = step + 3'd1;
            op_at_step(kind, data);
            if (kind == OP_NONE)
            begin
                phase = PH_IDLE;
                step = 3'd0;
                ticks = 0;
                done = 1'b1;
            end
            else
                open_bus_op(8'h00);
        endfunction

        function void advance_phase(logic bus);
            op_kind_t   kind;
            logic [7:0] data;
            if (ticks + 1 < span(phase))
            begin
                ticks++;
                return;
            end
            ticks = 0;
            case (phase)
                PH_RST_LOW:  phase = PH_RST_WAIT;
                PH_RST_WAIT:
                begin
                    presence = bus;
                    phase = PH_RST_REC;
                end
                PH_RST_REC:  close_bus_op();
                PH_WR_LOW:   phase = PH_HOLD;
                PH_RD_LOW:   phase = PH_RD_WAIT;
                PH_RD_WAIT:
                begin
                    if (bus) shifter[bit_no] = 1'b1;
                    phase = PH_HOLD;
                end
                PH_HOLD:
                begin
                    op_at_step(kind, data);
                    if (bit_no == BIT_LAST)
                    begin
                        if (kind == OP_READ)
                        begin
                            rx_last = shifter;
                            if (cmd_now == CMD_READ_TEMP && step == STEP_TEMP_LO)
                                temp_lo = rx_last;
                            else if (cmd_now == CMD_READ_TEMP && step == STEP_TEMP_HI)
                                temp_word = {rx_last, temp_lo};
                        end
                        close_bus_op();
                    end
                    else
                    begin
                        bit_no = bit_no + 3'd1;
                        phase = (kind == OP_READ) ? PH_RD_LOW : PH_WR_LOW;
                    end
                end
                default: phase = PH_IDLE;
            endcase
        endfunction

        // Step the predictor by one accepted tick word and hold its result
        function void accept_tick(logic [2:0] cmd, logic [7:0] tx, logic bus);
            result_t    want;
            op_kind_t   kind;
            logic [7:0] data;
            bit         valid;
            valid = (cmd >= CMD_RESET) && (cmd <= CMD_READ_TEMP);
            want = '0;
            done = 1'b0;
            if (phase == PH_IDLE)
            begin
                if (valid)
                begin
                    cmd_now = cmd;
                    step = 3'd0;
                    open_bus_op(tx);
                end
            end
            else
            begin
                want.command_ignored = valid;
                advance_phase(bus);
            end
            op_at_step(kind, data);
            if (phase == PH_RST_LOW || phase == PH_WR_LOW || phase == PH_RD_LOW)
                want.drive_low = 1'b1;
            else if (phase == PH_HOLD && kind != OP_READ)
                want.drive_low = ~shifter[bit_no];
            want.busy_res = (phase != PH_IDLE);
            want.done_res = done;
            want.presence_level = presence;
            want.rx_byte = rx_last;
            want.temperature_raw = temp_word;
            pending_results.push_back(want);
        endfunction

        task report(string what);
            mismatch_count++;
            $display("[%0t] result word %0d: %s", $time, checked_count, what);
        endtask

        task compare(string field, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("%s is %0h, expected %0h", field, got, want));
        endtask

        task check_result(result_t got);
            result_t want;
            checked_count++;
            if (pending_results.size() == 0)
            begin
                report("word arrived with nothing expected");
                return;
            end
            want = pending_results.pop_front();
            compare("drive_low", got.drive_low, want.drive_low);
            compare("busy_res", got.busy_res, want.busy_res);
            compare("done_res", got.done_res, want.done_res);
            compare("presence_level", got.presence_level, want.presence_level);
            compare("rx_byte", got.rx_byte, want.rx_byte);
            compare("temperature_raw", got.temperature_raw, want.temperature_raw);
            compare("command_ignored", got.command_ignored, want.command_ignored);
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [2:0]        command = CMD_TICK;
    logic [7:0]        tx_byte = 8'h00;
    logic              bus_level = 1'b1;
    logic              empty;
    logic              pop = 1'b0;
    logic              drive_low;
    logic              busy_res;
    logic              done_res;
    logic              presence_level;
    logic [7:0]        rx_byte;
    logic signed [15:0] temperature_raw;
    logic              command_ignored;
    logic              cfg_write = 1'b0;
    logic [2:0]        cfg_index = CFG_RST_LOW;
    logic [CFG_W-1:0]  cfg_data = '0;

    sensor_bus_model   sb;
    logic [CFG_W-1:0]  timing_plan [CFG_COUNT];
    int                tx_idle_pct = 0;
    int                rx_idle_pct = 0;
    int                cycle_count = 0;

    one_wire_sensor_master dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .command         (command),
        .tx_byte         (tx_byte),
        .bus_level       (bus_level),
        .empty           (empty),
        .pop             (pop),
        .drive_low       (drive_low),
        .busy_res        (busy_res),
        .done_res        (done_res),
        .presence_level  (presence_level),
        .rx_byte         (rx_byte),
        .temperature_raw (temperature_raw),
        .command_ignored (command_ignored),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("one_wire_sensor_master: mismatch");
            $finish;
        end
    end

    // Take result words, stalling at random
    initial
    begin
        result_t got;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                got.drive_low = drive_low;
                got.busy_res = busy_res;
                got.done_res = done_res;
                got.presence_level = presence_level;
                got.rx_byte = rx_byte;
                got.temperature_raw = temperature_raw;
                got.command_ignored = command_ignored;
                sb.check_result(got);
            end
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic line_level(input int mode);
        if (mode == BUS_RANDOM) return 1'($urandom_range(1));
        return (mode == BUS_HIGH);
    endfunction

    // Offer one tick word, idling at random first, and hold it until taken
    task automatic send_word(input logic [2:0] code, input logic [7:0] data, input logic bus);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        command <= code;
        tx_byte <= data;
        bus_level <= bus;
        do @(posedge clk); while (full);
        sb.accept_tick(code, data, bus);
    endtask

    // Hold the input back until every expected word is in, then wait a little
    task automatic drain(input int extra);
        push <= 1'b0;
        do @(posedge clk); while (sb.pending_results.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    // Write every timing register from the plan, then the unused index
    task automatic load_timings();
        for (int i = 0; i < CFG_COUNT; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= timing_plan[i];
            @(posedge clk);
            sb.timing[i] = timing_plan[i];
        end
        cfg_index <= CFG_SPARE;
        cfg_data <= CFG_W'($urandom_range(4095));
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Issue a word and keep ticking until the master goes idle
    task automatic run_command(input logic [2:0] code, input logic [7:0] data, input int mode,
                               input int stray_pct);
        logic [2:0] next_code;
        send_word(code, data, line_level(mode));
        while (!sb.idle())
        begin
            next_code = ($urandom_range(99) < stray_pct) ? 3'($urandom_range(1, 7)) : CMD_TICK;
            send_word(next_code, 8'($urandom_range(255)), line_level(mode));
        end
    endtask

    // Random traffic over three timing sets, commands issued mostly when idle
    task automatic random_stage(input int tx_pct, input int rx_pct);
        logic [2:0] code;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int sub = 0; sub < 3; sub++)
        begin
            drain(4);
            foreach (timing_plan[i])
                timing_plan[i] = CFG_W'($urandom_range(0, (sub == 2) ? 7 : sub + 2));
            load_timings();
            for (int n = 0; n < 105; n++)
            begin
                if ($urandom_range(399) == 0) drain(0);
                if (sb.idle() && $urandom_range(1) == 0)
                    code = ($urandom_range(9) == 0) ? 3'($urandom_range(7))
                                                    : 3'($urandom_range(CMD_RESET, CMD_READ_TEMP));
                else
                    code = ($urandom_range(11) == 0) ? 3'($urandom_range(7)) : CMD_TICK;
                send_word(code, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle words on reset timings, unused codes among them, then a read byte
        tx_idle_pct = 38;
        rx_idle_pct = 56;
        send_word(CMD_TICK, 8'h00, 1'b0);
        send_word(CMD_SPARE_7, 8'hFF, 1'b1);
        send_word(CMD_SPARE_6, 8'h5A, 1'b0);
        run_command(CMD_READ, 8'hA5, BUS_RANDOM, 10);

        // Every command on the shortest timings
        drain(4);
        foreach (timing_plan[i]) timing_plan[i] = CFG_W'(1);
        load_timings();
        run_command(CMD_WRITE, 8'h00, BUS_RANDOM, 0);
        run_command(CMD_WRITE, 8'hFF, BUS_RANDOM, 10);
        run_command(CMD_READ, 8'h00, BUS_HIGH, 0);
        run_command(CMD_READ, 8'hFF, BUS_LOW, 10);
        run_command(CMD_RESET, 8'h00, BUS_HIGH, 0);
        run_command(CMD_CONVERT, 8'h00, BUS_RANDOM, 10);
        run_command(CMD_READ_TEMP, 8'h00, BUS_HIGH, 0);
        run_command(CMD_READ_TEMP, 8'h00, BUS_LOW, 0);
        run_command(CMD_READ_TEMP, 8'h00, BUS_RANDOM, 10);

        // Zero timings behave as one tick
        drain(4);
        foreach (timing_plan[i]) timing_plan[i] = '0;
        load_timings();
        run_command(CMD_READ_TEMP, 8'h00, BUS_RANDOM, 10);

        // Shorten the reset pulse while it is under way
        drain(4);
        foreach (timing_plan[i]) timing_plan[i] = CFG_W'(1);
        timing_plan[CFG_RST_LOW] = CFG_W'(40);
        load_timings();
        send_word(CMD_RESET, 8'h00, 1'b1);
        repeat (10) send_word(CMD_TICK, 8'h00, 1'b1);
        drain(4);
        timing_plan[CFG_RST_LOW] = CFG_W'(3);
        load_timings();
        run_command(CMD_TICK, 8'h00, BUS_RANDOM, 0);

        random_stage(38, 56);
        random_stage(56, 38);
        random_stage(0, 0);

        drain(8);
        if (sb.mismatch_count == 0)
            $display("one_wire_sensor_master: match");
        else
            $display("one_wire_sensor_master: mismatch");
        $finish;
    end

endmodule

// ----- one_wire_sensor_master.f -----
design/owsm_pkg.sv
design/owsm_front.sv
design/owsm_engine.sv
design/owsm_resq.sv
design/one_wire_sensor_master.sv
test/tb_one_wire_sensor_master.sv
